/* rtl/weighted_server_task_dispatch_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the weighted server task dispatch block.
// Each macro builds one labeled concurrent assertion, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_SERVER_TASK_DISPATCH_TOP_ASSERT_SVH
`define WEIGHTED_SERVER_TASK_DISPATCH_TOP_ASSERT_SVH

// Same-cycle implication.
`define WSTD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wstd: same-cycle check failed");

// Next-cycle implication.
`define WSTD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wstd: next-cycle check failed");

`endif

/* rtl/wstd_pkg.sv */
// ----------------------------------------------------------------------------
// wstd_pkg
// Constants, types and helper functions shared by the dispatch cells and top.
// ----------------------------------------------------------------------------
`default_nettype none

package wstd_pkg;

    localparam int SERVERS   = 16;
    localparam int TIME_BITS = 48;

    localparam int IDX_W   = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int SLOT_W  = 4;
    localparam int WGT_W   = 20;
    localparam int DUR_W   = 20;
    localparam int START_W = 48;

    localparam int IN_BITS    = SLOT_W + WGT_W + DUR_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = SLOT_W + START_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int SUM_W = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 1;
    localparam int EXT_W = IDX_W + SLOT_W;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TASK = 1'b1;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [WGT_W-1:0]     t_wgt;

    // Search record that travels down the cell row.
    typedef struct packed {
        logic  vld;
        logic  found;
        t_wgt  fw;
        t_idx  fidx;
        logic  bany;
        t_time bb;
        t_wgt  bw;
        t_idx  bidx;
    } t_rec;

    // Write broadcast from the top to all cells.
    typedef struct packed {
        logic  busy_we;
        logic  wgt_we;
        t_idx  idx;
        t_time busy;
        t_wgt  wgt;
    } t_upd;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    function automatic t_time sat_add(input t_time a, input logic [DUR_W-1:0] d);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(d);
        if (s > SUM_W'(TIME_MAX)) begin
            return TIME_MAX;
        end
        return s[TIME_BITS-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] idx_to_slot(input t_idx idx);
        logic [EXT_W-1:0] e;
        e = {{SLOT_W{1'b0}}, idx};
        return e[SLOT_W-1:0];
    endfunction

    function automatic logic [START_W-1:0] time_to_start(input t_time t);
        logic [TIME_BITS+START_W-1:0] e;
        e = {{START_W{1'b0}}, t};
        return e[START_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/weighted_server_task_dispatch_top.sv */
// ----------------------------------------------------------------------------
// weighted_server_task_dispatch_top
// Task dispatcher over a row of server cells with weighted selection.
// ----------------------------------------------------------------------------
// Input beats arrive on the s_axis channel. tuser is the mode: a load beat
// writes one server weight in the cycle it is accepted and gives no result;
// a task beat starts a search that walks the row of server cells, one cell
// per cycle, and gives one result beat on the m_axis channel.
// After a task is accepted, its search record passes the cell row, then a
// register stage picks the server and forms the new busy-until time, then
// the commit loads the output register. A new beat is accepted only while
// no task is in progress, so a task is through before the next beat is
// taken, and loads go at one per cycle.
// The output register decouples the sides: the next beat is taken while a
// result waits. If the receiver still stalls when the next task finishes,
// that task holds before its commit until the output register frees.
// Reset clears all weights, busy-until times, the current time and the task
// count, so every server is free at time zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "weighted_server_task_dispatch_top_assert.svh"

module weighted_server_task_dispatch_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata: server_slot[3:0], weight[23:4], duration[43:24], zero pad above
    input  wire logic [wstd_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // tuser: mode[0]
    input  wire logic [0:0]                       i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // tdata: assigned_server[3:0], start_time[51:4], zero pad above
    output logic [wstd_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata
);

    wstd_pkg::t_state r_state;
    wstd_pkg::t_time  r_t0;
    wstd_pkg::t_time  r_t;
    wstd_pkg::t_time  r_nb;
    wstd_pkg::t_time  r_cur;
    wstd_pkg::t_time  r_task;
    wstd_pkg::t_idx   r_pick;
    logic [wstd_pkg::DUR_W-1:0] r_dur;
    logic             r_inject;
    logic             r_ovld;
    logic [wstd_pkg::OUT_DATA_W-1:0] r_odata;

    wstd_pkg::t_rec   w_rec [wstd_pkg::SERVERS+1];
    logic [wstd_pkg::SERVERS-1:0] w_vld;
    wstd_pkg::t_upd   w_upd;

    logic [wstd_pkg::SLOT_W-1:0] in_slot;
    wstd_pkg::t_wgt              in_wgt;
    logic [wstd_pkg::DUR_W-1:0]  in_dur;
    logic                        in_mode;
    logic [wstd_pkg::EXT_W-1:0]  slot_ext;
    logic                        slot_ok;
    logic                        acc;
    logic                        commit;
    wstd_pkg::t_rec              last;
    wstd_pkg::t_time             sel_t;

    assign in_slot  = i_s_axis_tdata[wstd_pkg::SLOT_W-1:0];
    assign in_wgt   = i_s_axis_tdata[wstd_pkg::SLOT_W+wstd_pkg::WGT_W-1:wstd_pkg::SLOT_W];
    assign in_dur   = i_s_axis_tdata[wstd_pkg::IN_BITS-1:wstd_pkg::SLOT_W+wstd_pkg::WGT_W];
    assign in_mode  = i_s_axis_tuser[0];
    assign slot_ext = {{wstd_pkg::IDX_W{1'b0}}, in_slot};
    assign slot_ok  = (slot_ext < wstd_pkg::EXT_W'(wstd_pkg::SERVERS));

    assign o_s_axis_tready = (r_state == wstd_pkg::ST_IDLE);
    assign acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign commit = (r_state == wstd_pkg::ST_FIN) && (!r_ovld || i_m_axis_tready);
    assign last   = w_rec[wstd_pkg::SERVERS];
    assign sel_t  = last.found ? r_t0 : last.bb;

    always_comb begin
        w_upd.busy_we = commit;
        w_upd.wgt_we  = acc && (in_mode == wstd_pkg::MODE_LOAD) && slot_ok;
        w_upd.idx     = commit ? r_pick : slot_ext[wstd_pkg::IDX_W-1:0];
        w_upd.busy    = r_nb;
        w_upd.wgt     = in_wgt;
    end

    always_comb begin
        w_rec[0]     = '0;
        w_rec[0].vld = r_inject;
    end

    for (genvar i = 0; i < wstd_pkg::SERVERS; i++) begin : g_cell
        wstd_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (wstd_pkg::IDX_W'(i)),
            .i_t        (r_t0),
            .i_rec      (w_rec[i]),
            .i_upd      (w_upd),
            .o_rec      (w_rec[i+1])
        );
        assign w_vld[i] = w_rec[i+1].vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wstd_pkg::ST_IDLE;
            r_inject <= 1'b0;
            r_ovld   <= 1'b0;
            r_cur    <= '0;
            r_task   <= '0;
        end else begin
            r_inject <= acc && (in_mode == wstd_pkg::MODE_TASK);
            if (commit) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && i_m_axis_tready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                wstd_pkg::ST_IDLE: begin
                    if (acc && (in_mode == wstd_pkg::MODE_TASK)) begin
                        r_t0     <= (r_cur > r_task) ? r_cur : r_task;
                        r_dur    <= in_dur;
                        r_state  <= wstd_pkg::ST_SCAN;
                    end
                end
                wstd_pkg::ST_SCAN: begin
                    if (last.vld) begin
                        r_pick  <= last.found ? last.fidx : last.bidx;
                        r_t     <= sel_t;
                        r_nb    <= wstd_pkg::sat_add(sel_t, r_dur);
                        r_state <= wstd_pkg::ST_FIN;
                    end
                end
                wstd_pkg::ST_FIN: begin
                    if (commit) begin
                        r_cur   <= r_t;
                        if (r_task != wstd_pkg::TIME_MAX) begin
                            r_task <= r_task + wstd_pkg::t_time'(1);
                        end
                        r_odata <= wstd_pkg::OUT_DATA_W'({wstd_pkg::time_to_start(r_t),
                                                          wstd_pkg::idx_to_slot(r_pick)});
                        r_state <= wstd_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= wstd_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = r_odata;

    `WSTD_ASSERT_IMP(a_one_record, i_clk, i_rst_n, 1'b1, $onehot0({w_vld, r_inject}))
    `WSTD_ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, r_state == wstd_pkg::ST_IDLE,
        (w_vld == '0) && !r_inject)
    `WSTD_ASSERT_NXT(a_task_injects, i_clk, i_rst_n,
        acc && (in_mode == wstd_pkg::MODE_TASK), r_inject)
    `WSTD_ASSERT_NXT(a_scan_ends, i_clk, i_rst_n,
        (r_state == wstd_pkg::ST_SCAN) && last.vld, r_state == wstd_pkg::ST_FIN)
    `WSTD_ASSERT_NXT(a_commit_shows, i_clk, i_rst_n, commit, o_m_axis_tvalid)

endmodule

`default_nettype wire

/* rtl/wstd_cell.sv */
// ----------------------------------------------------------------------------
// wstd_cell
// One server: holds its weight and busy-until time, folds itself into the
// passing search record and hands the record to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module wstd_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire wstd_pkg::t_idx   i_cell_idx,
    input  wire wstd_pkg::t_time  i_t,
    input  wire wstd_pkg::t_rec   i_rec,
    input  wire wstd_pkg::t_upd   i_upd,
    output wstd_pkg::t_rec        o_rec
);

    wstd_pkg::t_wgt  r_wgt;
    wstd_pkg::t_time r_busy;
    wstd_pkg::t_rec  r_rec;
    wstd_pkg::t_rec  n_rec;

    logic is_free;
    logic take_f;
    logic take_b;

    always_comb begin
        is_free = (r_busy <= i_t);
        take_f  = is_free && (!i_rec.found || (r_wgt < i_rec.fw));
        take_b  = !i_rec.bany || (r_busy < i_rec.bb) ||
                  ((r_busy == i_rec.bb) && (r_wgt < i_rec.bw));
        n_rec      = i_rec;
        n_rec.bany = 1'b1;
        if (take_f) begin
            n_rec.found = 1'b1;
            n_rec.fw    = r_wgt;
            n_rec.fidx  = i_cell_idx;
        end
        if (take_b) begin
            n_rec.bb   = r_busy;
            n_rec.bw   = r_wgt;
            n_rec.bidx = i_cell_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wgt  <= '0;
            r_busy <= '0;
            r_rec  <= '0;
        end else begin
            r_rec <= n_rec;
            if (i_upd.wgt_we && (i_upd.idx == i_cell_idx)) begin
                r_wgt <= i_upd.wgt;
            end
            if (i_upd.busy_we && (i_upd.idx == i_cell_idx)) begin
                r_busy <= i_upd.busy;
            end
        end
    end

    assign o_rec = r_rec;

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of weighted_server_task_dispatch_top
// Weight loads and task beats are driven in streams with random gaps and
// receiver stalls. A behavioral model of the dispatcher predicts the server
// and start time of every task, and each result beat is checked against it.
// ----------------------------------------------------------------------------

module tb;

    localparam int N_SRV     = wstd_pkg::SERVERS;
    localparam int IN_W      = wstd_pkg::IN_DATA_W;
    localparam int OUT_W     = wstd_pkg::OUT_DATA_W;
    localparam int PHASE_LEN = 425;
    localparam int CALM_FROM = 1500;
    localparam int HOLD_AT   = 500;
    localparam int HOLD_LEN  = 400;
    localparam int TAIL_WAIT = 40;

    typedef struct {
        logic        mode;
        logic [3:0]  slot;
        logic [19:0] wgt;
        logic [19:0] dur;
    } beat_t;

    typedef struct {
        logic [3:0]  srv;
        logic [47:0] start;
    } grant_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic [0:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    beat_t  stim_beats[$];
    grant_t expected_grants[$];
    beat_t  drv_beat;

    logic [19:0] srv_weight[N_SRV];
    logic [47:0] srv_busy[N_SRV];
    logic [47:0] now_time;
    logic [47:0] next_arrival;

    logic s_beat_taken = 1'b0;
    logic rx_hold = 1'b0;
    int   src_gap = 0;
    int   rx_gap = 0;
    int   beats_sent = 0;
    int   tasks_sent = 0;
    int   loads_sent = 0;
    int   all_busy_cnt = 0;
    int   grants_seen = 0;
    int   err_cnt = 0;
    logic [47:0] latest_start = '0;

    wire idle_on = (beats_sent < CALM_FROM);

    weighted_server_task_dispatch_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_cnt < 20) begin
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        err_cnt++;
    endtask

    task automatic grant_task(input logic [19:0] dur);
        logic [47:0] t;
        logic [48:0] sum;
        int          pick;
        bit          found;
        grant_t      g;
        t = (now_time > next_arrival) ? now_time : next_arrival;
        found = 1'b0;
        pick = 0;
        for (int i = 0; i < N_SRV; i++) begin
            if (srv_busy[i] <= t && (!found || srv_weight[i] < srv_weight[pick])) begin
                pick = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            all_busy_cnt++;
            for (int i = 1; i < N_SRV; i++) begin
                if (srv_busy[i] < srv_busy[pick] ||
                    (srv_busy[i] == srv_busy[pick] && srv_weight[i] < srv_weight[pick])) begin
                    pick = i;
                end
            end
            t = srv_busy[pick];
        end
        sum = {1'b0, t} + 49'(dur);
        srv_busy[pick] = (sum > 49'(wstd_pkg::TIME_MAX)) ? wstd_pkg::TIME_MAX : sum[47:0];
        now_time = t;
        if (next_arrival != wstd_pkg::TIME_MAX) begin
            next_arrival++;
        end
        g.srv = 4'(pick);
        g.start = t;
        expected_grants = {expected_grants, g};
    endtask

    task automatic check_grant(input logic [OUT_W-1:0] data);
        grant_t g;
        grants_seen++;
        if (expected_grants.size() == 0) begin
            report_mismatch("result beat with nothing expected", 64'(data), 64'd0);
        end else begin
            g = expected_grants.pop_front();
            if (data[3:0] !== g.srv) begin
                report_mismatch("assigned_server", 64'(data[3:0]), 64'(g.srv));
            end
            if (data[51:4] !== g.start) begin
                report_mismatch("start_time", 64'(data[51:4]), 64'(g.start));
            end
            if (data[OUT_W-1:52] !== '0) begin
                report_mismatch("tdata pad", 64'(data[OUT_W-1:52]), 64'd0);
            end
            if (g.start > latest_start) begin
                latest_start = g.start;
            end
        end
    endtask

    function automatic beat_t make_beat(input int wspan);
        beat_t b;
        int    sel;
        b.mode = ($urandom_range(0, 4) == 0) ? wstd_pkg::MODE_LOAD : wstd_pkg::MODE_TASK;
        b.slot = 4'($urandom);
        b.wgt = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, wspan));
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            b.dur = 20'($urandom_range(0, 24));
        end else if (sel < 80) begin
            b.dur = 20'($urandom_range(0, 200));
        end else if (sel < 95) begin
            b.dur = 20'($urandom_range(0, 2000));
        end else begin
            b.dur = 20'($urandom);
        end
        return b;
    endfunction

    function automatic beat_t mk(input logic mode, input logic [3:0] slot,
                                 input logic [19:0] wgt, input logic [19:0] dur);
        beat_t b;
        b.mode = mode;
        b.slot = slot;
        b.wgt = wgt;
        b.dur = dur;
        return b;
    endfunction

    // Input side: sample accepted beats, run the model, check result beats.
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                check_grant(m_tdata);
            end
            s_beat_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                beats_sent++;
                if (s_tuser[0] == wstd_pkg::MODE_LOAD) begin
                    loads_sent++;
                    srv_weight[s_tdata[3:0]] = s_tdata[23:4];
                end else begin
                    tasks_sent++;
                    grant_task(s_tdata[43:24]);
                end
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n && (!s_tvalid || s_beat_taken)) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (stim_beats.size() > 0) begin
                drv_beat = stim_beats.pop_front();
                s_tdata <= {4'b0, drv_beat.dur, drv_beat.wgt, drv_beat.slot};
                s_tuser <= drv_beat.mode;
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) begin
                    src_gap <= $urandom_range(1, 7);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n || rx_hold) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 9) == 0) begin
                rx_gap <= $urandom_range(1, 7);
            end
        end
    end

    // The receiver stops for a long stretch while the sender keeps offering beats.
    initial begin
        while (tasks_sent < HOLD_AT) begin
            @(negedge clk);
        end
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic wait_drained();
        while (stim_beats.size() != 0 || s_tvalid || expected_grants.size() != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin
        int wspan;
        for (int i = 0; i < N_SRV; i++) begin
            srv_weight[i] = '0;
            srv_busy[i] = '0;
        end
        now_time = '0;
        next_arrival = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        stim_beats = {stim_beats, mk(wstd_pkg::MODE_TASK, 4'hF, 20'hFFFFF, 20'd0)};
        stim_beats = {stim_beats, mk(wstd_pkg::MODE_TASK, 4'h0, 20'h00000, 20'hFFFFF)};
        stim_beats = {stim_beats, mk(wstd_pkg::MODE_LOAD, 4'h0, 20'hFFFFF, 20'hFFFFF)};
        stim_beats = {stim_beats, mk(wstd_pkg::MODE_LOAD, 4'hF, 20'h00000, 20'h00000)};
        for (int i = 1; i < N_SRV - 1; i++) begin
            stim_beats = {stim_beats, mk(wstd_pkg::MODE_LOAD, 4'(i), 20'(i % 4 + 1), 20'd0)};
        end
        for (int i = 0; i < 6; i++) begin
            stim_beats = {stim_beats, mk(wstd_pkg::MODE_TASK, 4'(i), 20'(i), 20'd1 + 20'(i))};
        end
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: wspan = 3;
                1: wspan = 255;
                2: wspan = 20'hFFFFF;
                default: wspan = 1;
            endcase
            for (int i = 0; i < PHASE_LEN; i++) begin
                stim_beats = {stim_beats, make_beat(wspan)};
            end
            wait_drained();
        end

        repeat (TAIL_WAIT) @(posedge clk);
        if (expected_grants.size() != 0) begin
            report_mismatch("results never delivered", 64'(expected_grants.size()), 64'd0);
        end
        $display("Covered %0d task beats (%0d found every server busy) and %0d weight loads.",
                 tasks_sent, all_busy_cnt, loads_sent);
        $display("Checked %0d result beats; latest start time %0d.", grants_seen, latest_start);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
